### src/pprc_pkg.sv
// shared types and constants for the pwm prescaler / reload / compare calculator
package pprc_pkg;

   // field widths
   localparam int ActionWidth = 2;
   localparam int FreqWidth   = 28;
   localparam int DutyWidth   = 14;
   localparam int TimerWidth  = 16;

   // divider sizing: dividend covers duty * (reload + 1) < 2^30
   localparam int DivWidth    = 30;
   localparam int DenWidth    = 28;
   localparam int CntWidth    = $clog2(DivWidth);

   localparam logic [FreqWidth-1:0]  ClockResetHz  = FreqWidth'(72000000);
   localparam logic [FreqWidth-1:0]  DefaultFreqHz = FreqWidth'(1000);
   localparam logic [DenWidth-1:0]   PeriodLimit   = DenWidth'(65535);
   localparam logic [DutyWidth-1:0]  DutyFull      = DutyWidth'(10000);
   localparam logic [TimerWidth-1:0] ReloadReset   = TimerWidth'(65535);

   localparam logic [ActionWidth-1:0] ActInit    = 2'd0;
   localparam logic [ActionWidth-1:0] ActSetFreq = 2'd1;
   localparam logic [ActionWidth-1:0] ActSetDuty = 2'd2;

   // divider launch request
   typedef struct packed {
      logic                start;
      logic [DivWidth-1:0] dividend;
      logic [DenWidth-1:0] divisor;
   } div_req_type;

   // divider status
   typedef struct packed {
      logic                done;
      logic [DivWidth-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_PERIOD = 7'b0000010,
      ST_PSC    = 7'b0000100,
      ST_RELOAD = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_CMP    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage

### src/pprc_div.sv
// shared restoring divider, one quotient bit per cycle
module pprc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pprc_pkg::div_req_type req,
   output pprc_pkg::div_rsp_type rsp
);
   import pprc_pkg::*;

   logic [DenWidth-1:0] rem_ff, rem_in;
   logic [DivWidth-1:0] quo_ff, quo_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [DenWidth:0]   shifted;
   logic [DenWidth:0]   diff;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[DivWidth-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
         cnt_in  = CntWidth'(DivWidth - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_in = fits ? diff[DenWidth-1:0] : shifted[DenWidth-1:0];
         quo_in = {quo_ff[DivWidth-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### src/pwm_prescale_reload_compare_calc_core.sv
// top level: pwm prescaler, auto-reload and compare calculator for one channel
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  req      | req_valid / req_ready    | req_action, req_freq_hz, req_duty
//  rsp      | rsp_valid / rsp_ready    | rsp_prescaler, rsp_reload, rsp_compare,
//           |                          | rsp_ignored
//  csr      | csr_write_en             | csr_write_data (timer_clock_hz)
//
// one item at a time; every division runs on the shared divider at one bit a cycle.
// init with a long period runs four divisions, one multiply state and the output state;
// short periods or single actions take fewer steps.
// a set frequency of zero, or an undefined action, goes straight to the output state.
// reset restores timer_clock_hz to 72 MHz, prescaler 0, reload 65535, compare 0.
// a finished item waits in the output register; the next item is taken meanwhile.
module pwm_prescale_reload_compare_calc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pprc_pkg::ActionWidth-1:0]    req_action,
   input  logic [pprc_pkg::FreqWidth-1:0]      req_freq_hz,
   input  logic [pprc_pkg::DutyWidth-1:0]      req_duty,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pprc_pkg::TimerWidth-1:0]     rsp_prescaler,
   output logic [pprc_pkg::TimerWidth-1:0]     rsp_reload,
   output logic [pprc_pkg::TimerWidth-1:0]     rsp_compare,
   output logic                                rsp_ignored,
   input  logic                                csr_write_en,
   input  logic [pprc_pkg::FreqWidth-1:0]      csr_write_data
);
   import pprc_pkg::*;

   state_type state_ff, state_in;

   // configuration and timer state
   logic [FreqWidth-1:0]  clk_hz_ff;
   logic [TimerWidth-1:0] prescaler_ff, prescaler_in;
   logic [TimerWidth-1:0] reload_ff, reload_in;
   logic [TimerWidth-1:0] compare_ff, compare_in;

   // per-item working registers
   logic                  want_cmp_ff, want_cmp_in;   // init also needs a compare
   logic                  ignored_ff, ignored_in;
   logic [DutyWidth-1:0]  duty_ff, duty_in;
   logic [FreqWidth-1:0]  period_ff, period_in;
   logic [TimerWidth-1:0] psc_ff, psc_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TimerWidth-1:0] rsp_prescaler_ff, rsp_prescaler_in;
   logic [TimerWidth-1:0] rsp_reload_ff, rsp_reload_in;
   logic [TimerWidth-1:0] rsp_compare_ff, rsp_compare_in;
   logic                  rsp_ignored_ff, rsp_ignored_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                   accept;
   logic [FreqWidth-1:0]   freq_eff;
   logic [DutyWidth-1:0]   duty_clamped;
   logic [DivWidth-1:0]    product;
   logic [TimerWidth:0]    psc_plus_one;

   pprc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign freq_eff     = (req_freq_hz == '0) ? DefaultFreqHz : req_freq_hz;
   assign duty_clamped = (req_duty > DutyFull) ? DutyFull : req_duty;
   // duty <= 10000 and reload + 1 <= 65536, so the product stays below 2^30
   assign product      = DivWidth'(duty_ff) *
                         DivWidth'({1'b0, reload_ff} + 17'd1);
   assign psc_plus_one = {1'b0, div_rsp.quotient[TimerWidth-1:0]} + 17'd1;

   always_comb begin
      state_in         = state_ff;
      prescaler_in     = prescaler_ff;
      reload_in        = reload_ff;
      compare_in       = compare_ff;
      want_cmp_in      = want_cmp_ff;
      ignored_in       = ignored_ff;
      duty_in          = duty_ff;
      period_in        = period_ff;
      psc_in           = psc_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_prescaler_in = rsp_prescaler_ff;
      rsp_reload_in    = rsp_reload_ff;
      rsp_compare_in   = rsp_compare_ff;
      rsp_ignored_in   = rsp_ignored_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               duty_in     = duty_clamped;
               ignored_in  = 1'b0;
               want_cmp_in = (req_action == ActInit);
               case (req_action)
                  ActInit: begin
                     // period = clock / freq
                     div_req.start    = 1'b1;
                     div_req.dividend = DivWidth'(clk_hz_ff);
                     div_req.divisor  = freq_eff;
                     state_in         = ST_PERIOD;
                  end
                  ActSetFreq: begin
                     if (req_freq_hz == '0) begin
                        ignored_in = 1'b1;
                        state_in   = ST_DONE;
                     end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DivWidth'(clk_hz_ff);
                        div_req.divisor  = req_freq_hz;
                        state_in         = ST_PERIOD;
                     end
                  end
                  ActSetDuty: begin
                     state_in = ST_MUL;
                  end
                  default: begin
                     // undefined action: report state as it stands
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_PERIOD: begin
            if (div_rsp.done) begin
               period_in = div_rsp.quotient[FreqWidth-1:0];
               if (div_rsp.quotient < DivWidth'(PeriodLimit)) begin
                  // short period: no prescaling, zero period wraps to 65535
                  prescaler_in = '0;
                  reload_in    = div_rsp.quotient[TimerWidth-1:0] - 1'b1;
                  state_in     = want_cmp_ff ? ST_MUL : ST_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
                  div_req.divisor  = PeriodLimit;
                  state_in         = ST_PSC;
               end
            end
         end
         ST_PSC: begin
            if (div_rsp.done) begin
               psc_in           = div_rsp.quotient[TimerWidth-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = DivWidth'(period_ff);
               div_req.divisor  = DenWidth'(psc_plus_one);
               state_in         = ST_RELOAD;
            end
         end
         ST_RELOAD: begin
            if (div_rsp.done) begin
               prescaler_in = psc_ff;
               reload_in    = div_rsp.quotient[TimerWidth-1:0] - 1'b1;
               state_in     = want_cmp_ff ? ST_MUL : ST_DONE;
            end
         end
         ST_MUL: begin
            // product goes straight into the divider's registers
            div_req.start    = 1'b1;
            div_req.dividend = product;
            div_req.divisor  = DenWidth'(DutyFull);
            state_in         = ST_CMP;
         end
         ST_CMP: begin
            if (div_rsp.done) begin
               // full duty at reload 65535 gives 65536, kept to 16 bits
               compare_in = div_rsp.quotient[TimerWidth-1:0];
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_prescaler_in = prescaler_ff;
               rsp_reload_in    = reload_ff;
               rsp_compare_in   = compare_ff;
               rsp_ignored_in   = ignored_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clk_hz_ff    <= ClockResetHz;
         prescaler_ff <= '0;
         reload_ff    <= ReloadReset;
         compare_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prescaler_ff <= prescaler_in;
         reload_ff    <= reload_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            clk_hz_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      want_cmp_ff      <= want_cmp_in;
      ignored_ff       <= ignored_in;
      duty_ff          <= duty_in;
      period_ff        <= period_in;
      psc_ff           <= psc_in;
      rsp_prescaler_ff <= rsp_prescaler_in;
      rsp_reload_ff    <= rsp_reload_in;
      rsp_compare_ff   <= rsp_compare_in;
      rsp_ignored_ff   <= rsp_ignored_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prescaler = rsp_prescaler_ff;
   assign rsp_reload    = rsp_reload_ff;
   assign rsp_compare   = rsp_compare_ff;
   assign rsp_ignored   = rsp_ignored_ff;

endmodule

### tb/tb.sv
// self-checking testbench for the pwm prescaler / reload / compare calculator
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pprc_pkg::*;

   localparam logic [ActionWidth-1:0] ActUndefined = 2'd3;
   localparam logic [FreqWidth-1:0]   ClockAllOnes = 28'hFFFFFFF;
   localparam logic [FreqWidth-1:0]   ClockMaxHz   = FreqWidth'(200000000);
   localparam int ResetCycles  = 6;
   localparam int SettleCycles = 160;     // a bit more than the longest item
   localparam int CycleLimit   = 400000;
   localparam int PhaseItems   = 100;

   // one expected result item
   typedef struct packed {
      logic [TimerWidth-1:0] prescaler;
      logic [TimerWidth-1:0] reload;
      logic [TimerWidth-1:0] compare;
      logic                  ignored;
   } timer_setting_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ActionWidth-1:0] req_action = '0;
   logic [FreqWidth-1:0]   req_freq_hz = '0;
   logic [DutyWidth-1:0]   req_duty = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TimerWidth-1:0]  rsp_prescaler;
   logic [TimerWidth-1:0]  rsp_reload;
   logic [TimerWidth-1:0]  rsp_compare;
   logic                   rsp_ignored;
   logic                   csr_write_en = 1'b0;
   logic [FreqWidth-1:0]   csr_write_data = '0;

   // shadow copy of the block's registers
   logic [FreqWidth-1:0]   shadow_clock_hz = ClockResetHz;
   logic [TimerWidth-1:0]  shadow_prescaler = '0;
   logic [TimerWidth-1:0]  shadow_reload = ReloadReset;
   logic [TimerWidth-1:0]  shadow_compare = '0;

   timer_setting_type pending_settings[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int rsp_count      = 0;
   int cycle_count    = 0;

   pwm_prescale_reload_compare_calc_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_freq_hz    (req_freq_hz),
      .req_duty       (req_duty),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prescaler  (rsp_prescaler),
      .rsp_reload     (rsp_reload),
      .rsp_compare    (rsp_compare),
      .rsp_ignored    (rsp_ignored),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // split clock/freq into prescaler and reload; freq is never zero here
   task automatic update_timebase(input logic [FreqWidth-1:0] freq);
      logic [31:0] period;
      logic [31:0] psc_wide;
      logic [31:0] per_tick;
      period = 32'(shadow_clock_hz) / 32'(freq);
      if (period < 32'(PeriodLimit)) begin
         shadow_prescaler = '0;
         // period zero wraps to 65535 here
         shadow_reload = 16'(period - 32'd1);
      end else begin
         psc_wide = period / 32'(PeriodLimit);
         shadow_prescaler = psc_wide[TimerWidth-1:0];
         per_tick = period / (32'(shadow_prescaler) + 32'd1);
         shadow_reload = 16'(per_tick - 32'd1);
      end
   endtask

   // compare from the stored reload, duty clamped to full scale
   task automatic update_compare(input logic [DutyWidth-1:0] duty);
      logic [31:0] clamped;
      logic [31:0] product;
      clamped = (duty > DutyFull) ? 32'(DutyFull) : 32'(duty);
      product = clamped * (32'(shadow_reload) + 32'd1);
      // full duty at reload 65535 gives 65536, which keeps only its low 16 bits
      shadow_compare = 16'(product / 32'(DutyFull));
   endtask

   task automatic predict_setting(input logic [ActionWidth-1:0] action,
                                  input logic [FreqWidth-1:0] freq,
                                  input logic [DutyWidth-1:0] duty,
                                  output timer_setting_type setting);
      logic ignored;
      ignored = 1'b0;
      case (action)
         ActInit: begin
            update_timebase((freq == '0) ? DefaultFreqHz : freq);
            update_compare(duty);
         end
         ActSetFreq: begin
            // compare is kept as it is
            if (freq == '0) ignored = 1'b1;
            else update_timebase(freq);
         end
         ActSetDuty: begin
            update_compare(duty);
         end
         default: begin
            // undefined action only reports the current state
         end
      endcase
      setting.prescaler = shadow_prescaler;
      setting.reload    = shadow_reload;
      setting.compare   = shadow_compare;
      setting.ignored   = ignored;
   endtask

   // ---------------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------------

   // sends one item; valid is left high so back-to-back items need no dip
   task automatic send_item(input logic [ActionWidth-1:0] action,
                            input logic [FreqWidth-1:0] freq,
                            input logic [DutyWidth-1:0] duty);
      timer_setting_type setting;
      // sender idles cycle by cycle before offering the item
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= action;
      req_freq_hz <= freq;
      req_duty    <= duty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // accepted at this edge
      predict_setting(action, freq, duty, setting);
      pending_settings.push_back(setting);
   endtask

   // stop sending and wait until the block has nothing in flight
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_settings.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // register write, only once the block is idle
   task automatic set_timer_clock(input logic [FreqWidth-1:0] hz);
      drain_and_settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= hz;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      shadow_clock_hz = hz;
   endtask

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at item %0d: %s got %0d expected %0d", rsp_count, what, got, want);
      fail_count++;
   endtask

   task automatic check_result();
      timer_setting_type want;
      if (pending_settings.size() == 0) begin
         report_mismatch("item with none expected, prescaler", rsp_prescaler, 0);
      end else begin
         want = pending_settings.pop_front();
         if (rsp_prescaler !== want.prescaler)
            report_mismatch("prescaler", rsp_prescaler, want.prescaler);
         if (rsp_reload !== want.reload)
            report_mismatch("reload", rsp_reload, want.reload);
         if (rsp_compare !== want.compare)
            report_mismatch("compare", rsp_compare, want.compare);
         if (rsp_ignored !== want.ignored)
            report_mismatch("ignored", rsp_ignored, want.ignored);
      end
      rsp_count++;
   endtask

   // receiver: check on accept, then pick the next ready at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_result();
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("[pwm_prescale_reload_compare_calc_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // state right after reset, and full duty overflowing against reload 65535
   task automatic test_reset_state();
      send_item(ActUndefined, '0, '0);
      send_item(ActSetDuty, '0, DutyFull);
      send_item(ActSetDuty, '0, 14'h3FFF);
      send_item(ActSetFreq, '0, 14'h3FFF);
   endtask

   // every action and field extreme at the reset clock of 72 MHz
   task automatic test_actions_reset_clock();
      send_item(ActInit, '0, 14'd5000);              // zero freq taken as 1000
      send_item(ActInit, 28'd1, DutyFull);           // longest period
      send_item(ActInit, 28'hFFFFFFF, 14'd1);        // freq above clock, period zero
      send_item(ActSetFreq, 28'd1098, '0);           // just above the period limit
      send_item(ActSetFreq, 28'd1099, '0);           // just below it, compare kept
      send_item(ActSetFreq, '0, 14'h3FFF);           // ignored
      send_item(ActSetDuty, '0, '0);
      send_item(ActSetDuty, '0, 14'd10001);          // clamped
      send_item(ActUndefined, 28'hFFFFFFF, 14'h3FFF);
   endtask

   // clock register extremes, period exactly at and next to the limit
   task automatic test_clock_extremes();
      set_timer_clock(FreqWidth'(65535));
      send_item(ActInit, 28'd1, DutyFull);           // period equal to the limit
      set_timer_clock(FreqWidth'(65534));
      send_item(ActInit, 28'd1, DutyFull);           // one below the limit
      set_timer_clock(FreqWidth'(1));
      send_item(ActInit, 28'd1, 14'd9999);           // reload zero
      send_item(ActSetFreq, 28'd2, '0);              // period zero
      set_timer_clock('0);
      send_item(ActInit, 28'd7, 14'd3333);           // zero clock
      set_timer_clock(ClockAllOnes);
      send_item(ActInit, 28'd1, 14'h3FFF);
      send_item(ActSetDuty, '0, 14'd1);
      set_timer_clock(ClockMaxHz);
      send_item(ActInit, 28'd3, DutyFull);
   endtask

   // random items under one idling pattern and one clock setting
   task automatic test_random_phase(input int send_pct, input int stall_pct,
                                    input logic [FreqWidth-1:0] hz);
      logic [ActionWidth-1:0] action;
      logic [FreqWidth-1:0]   freq;
      logic [FreqWidth-1:0]   mask;
      logic [DutyWidth-1:0]   duty;
      int pick;
      set_timer_clock(hz);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      repeat (PhaseItems) begin
         pick = $urandom_range(99);
         if (pick < 45) action = ActInit;
         else if (pick < 70) action = ActSetFreq;
         else if (pick < 95) action = ActSetDuty;
         else action = ActUndefined;

         // frequency spread over magnitudes so both timebase branches are hit
         pick = $urandom_range(99);
         if (pick < 10) begin
            freq = '0;
         end else if (pick < 25) begin
            freq = FreqWidth'(shadow_clock_hz / PeriodLimit) + FreqWidth'($urandom_range(0, 2));
         end else begin
            mask = (FreqWidth'(1) << $urandom_range(1, FreqWidth)) - FreqWidth'(1);
            freq = FreqWidth'($urandom) & mask;
         end

         pick = $urandom_range(99);
         if (pick < 10) duty = DutyFull;
         else if (pick < 40) duty = DutyWidth'($urandom);
         else duty = DutyWidth'($urandom_range(0, 10000));

         send_item(action, freq, duty);
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_actions_reset_clock();
      test_clock_extremes();

      // no idling, sender idle, receiver stalling, both
      test_random_phase(0, 0, ClockResetHz);
      test_random_phase(46, 0, ClockMaxHz);
      test_random_phase(0, 46, FreqWidth'($urandom_range(1, 200000000)));
      test_random_phase(27, 27, FreqWidth'($urandom));

      drain_and_settle();
      if (fail_count == 0) begin
         $display("[pwm_prescale_reload_compare_calc_core] OK");
      end else begin
         $display("[pwm_prescale_reload_compare_calc_core] ERROR");
      end
      $finish;
   end

endmodule

### pwm_prescale_reload_compare_calc_core.f
src/pprc_pkg.sv
src/pprc_div.sv
src/pwm_prescale_reload_compare_calc_core.sv
tb/tb.sv
